/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion wrappers, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

/* rtl/trtt_pkg.sv */
// ----------------------------------------------------------------------------
// trtt_pkg
// Types and constants of the TCP time-wait / retransmission timer table.
// ----------------------------------------------------------------------------
package trtt_pkg;

   // field widths
   localparam int SI_W     = 20;   // scan interval
   localparam int RI_W     = 20;   // initial retransmission timeout
   localparam int TW_W     = 24;   // time-wait timeout
   localparam int MR_W     = 3;    // max retries
   localparam int CNT_W    = 3;    // retry count
   localparam int RT_REM_W = RI_W + (1 << CNT_W) - 1;  // initial << up to 7
   localparam int WIN_W    = 16;
   localparam int CONN_W   = 4;
   localparam int MODE_W   = 3;
   localparam int ACT_W    = 3;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   // register reset values
   localparam logic [SI_W-1:0] SI_RESET = SI_W'(10000);
   localparam logic [RI_W-1:0] RI_RESET = RI_W'(200000);
   localparam logic [TW_W-1:0] TW_RESET = TW_W'(1000000);
   localparam logic [MR_W-1:0] MR_RESET = MR_W'(3);

   // register indexes (byte address / 4)
   typedef enum logic [1:0] {
      REG_SCAN_INTERVAL    = 2'd0,
      REG_RETRANS_INITIAL  = 2'd1,
      REG_TIMEWAIT_TIMEOUT = 2'd2,
      REG_MAX_RETRIES      = 2'd3
   } reg_type;

   // request kinds
   typedef enum logic [MODE_W-1:0] {
      MODE_SCAN     = 3'd0,
      MODE_TW_START = 3'd1,
      MODE_RT_START = 3'd2,
      MODE_RT_STOP  = 3'd3,
      MODE_ACK      = 3'd4
   } mode_type;

   // result kinds
   typedef enum logic [ACT_W-1:0] {
      ACT_SCAN_DONE = 3'd0,
      ACT_TW_CLOSE  = 3'd1,
      ACT_RETX      = 3'd2,
      ACT_RESET     = 3'd3,
      ACT_DROP      = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EV_RD,
      ST_EV_WR,
      ST_SC_RD,
      ST_SC_TW,
      ST_SC_RT,
      ST_SC_DONE
   } state_type;

   // one table row per connection
   typedef struct packed {
      logic                tw_active;
      logic [TW_W-1:0]     tw_rem;
      logic [CNT_W-1:0]    rt_count;   // 0 = retransmission timer off
      logic [RT_REM_W-1:0] rt_rem;
      logic                unacked;
      logic [WIN_W-1:0]    window;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{
      tw_active: 1'b0,
      tw_rem:    '0,
      rt_count:  '0,
      rt_rem:    '0,
      unacked:   1'b0,
      window:    WIN_W'(1)
   };

endpackage

/* rtl/tcp_retrans_timewait_timer_table.sv */
// ----------------------------------------------------------------------------
// tcp_retrans_timewait_timer_table
// Per-connection time-wait and retransmission timers held in one table RAM.
// ----------------------------------------------------------------------------
// Usage:
//  req channel: one beat per event. tuser carries the kind (scan tick, start
//  time-wait, start/stop retransmission, ack update), tdata the connection,
//  ack flags and congestion window.
//  rsp channel: only a scan tick produces beats: one per expired timer in
//  connection order (time-wait before retransmission), then a scan-done beat
//  with tlast high.
//  Events on a connection step through read, modify/write, back to idle.
//  A scan tick steps through read, time-wait and retransmission/write-back
//  for each connection, then the scan-done beat; the single table RAM port
//  is visited once per row. Events on connections at or above
//  CONNECTIONS and unknown kinds are taken and dropped.
//  When rsp stalls, the scan holds at the expiring timer; the output register
//  lets a new request be accepted while the last beat still waits.
//  Reset loads register defaults and marks all rows invalid; an invalid row
//  reads as its reset value, so no clearing pass is needed.
//  csr: APB-style, registers at byte addresses 0, 4, 8, 12; write only while
//  the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcp_retrans_timewait_timer_table #(
   parameter int CONNECTIONS = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // conn[3:0], acked_some[4], buffer_empty[5],
                                    // cwnd_now[21:6], zero pad[23:22]
   input  logic [2:0]  req_tuser,   // mode[2:0]

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_conn[3:0], new_cwnd[19:4],
                                    // new_ssthresh[35:20], zero pad[39:36]
   output logic [2:0]  rsp_tuser,   // action[2:0]
   output logic        rsp_tlast,   // last

   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [trtt_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [trtt_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [trtt_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);

   localparam int IDX_W = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CONNECTIONS - 1);

   // configuration registers
   logic [trtt_pkg::SI_W-1:0] si_ff;
   logic [trtt_pkg::RI_W-1:0] ri_ff;
   logic [trtt_pkg::TW_W-1:0] tw_ff;
   logic [trtt_pkg::MR_W-1:0] mr_ff;
   logic                      csr_wr;

   // control
   trtt_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                req_accept;
   logic                req_conn_ok;
   logic                req_mode_ok;

   // captured request
   logic [trtt_pkg::MODE_W-1:0] mode_ff;
   logic [IDX_W-1:0]            conn_ff;
   logic                        acked_ff;
   logic                        empty_ff;
   logic [trtt_pkg::WIN_W-1:0]  cwnd_ff;

   // table RAM and row valid bits
   trtt_pkg::entry_type tbl_mem [CONNECTIONS];
   trtt_pkg::entry_type rd_data_ff;
   logic                rd_vld_ff;
   logic [CONNECTIONS-1:0] vld_ff;
   logic                mem_rd_en;
   logic                mem_wr_en;
   logic [IDX_W-1:0]    mem_addr;
   trtt_pkg::entry_type mem_wr_data;

   // working row and timer decisions
   trtt_pkg::entry_type cur_entry;
   trtt_pkg::entry_type entry_ff, entry_in;
   logic                tw_expire;
   logic                rt_expire;
   logic                out_free;

   // result register
   logic                          push;
   logic                          rsp_valid_ff;
   logic [trtt_pkg::CONN_W-1:0]   res_conn, rsp_conn_ff;
   logic [trtt_pkg::ACT_W-1:0]    res_act, rsp_act_ff;
   logic [trtt_pkg::WIN_W-1:0]    res_cwnd, rsp_cwnd_ff;
   logic [trtt_pkg::WIN_W-1:0]    res_ss, rsp_ss_ff;
   logic                          res_last, rsp_last_ff;

   // expiry helpers
   logic [trtt_pkg::WIN_W-1:0]    half_win;
   logic [trtt_pkg::CNT_W:0]      cnt_next;

   // -------------------------------------------------------------------------
   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         si_ff <= trtt_pkg::SI_RESET;
         ri_ff <= trtt_pkg::RI_RESET;
         tw_ff <= trtt_pkg::TW_RESET;
         mr_ff <= trtt_pkg::MR_RESET;
      end else if (csr_wr) begin
         unique case (trtt_pkg::reg_type'(csr_paddr[3:2]))
            trtt_pkg::REG_SCAN_INTERVAL:    si_ff <= csr_pwdata[trtt_pkg::SI_W-1:0];
            trtt_pkg::REG_RETRANS_INITIAL:  ri_ff <= csr_pwdata[trtt_pkg::RI_W-1:0];
            trtt_pkg::REG_TIMEWAIT_TIMEOUT: tw_ff <= csr_pwdata[trtt_pkg::TW_W-1:0];
            trtt_pkg::REG_MAX_RETRIES:      mr_ff <= csr_pwdata[trtt_pkg::MR_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (trtt_pkg::reg_type'(csr_paddr[3:2]))
         trtt_pkg::REG_SCAN_INTERVAL:    csr_prdata = trtt_pkg::CSR_DW'(si_ff);
         trtt_pkg::REG_RETRANS_INITIAL:  csr_prdata = trtt_pkg::CSR_DW'(ri_ff);
         trtt_pkg::REG_TIMEWAIT_TIMEOUT: csr_prdata = trtt_pkg::CSR_DW'(tw_ff);
         trtt_pkg::REG_MAX_RETRIES:      csr_prdata = trtt_pkg::CSR_DW'(mr_ff);
      endcase
   end

   // -------------------------------------------------------------------------
   // Request capture
   assign req_tready  = (state_ff == trtt_pkg::ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign req_conn_ok = int'(req_tdata[trtt_pkg::CONN_W-1:0]) < CONNECTIONS;
   assign req_mode_ok = (req_tuser == trtt_pkg::MODE_TW_START) ||
                        (req_tuser == trtt_pkg::MODE_RT_START) ||
                        (req_tuser == trtt_pkg::MODE_RT_STOP)  ||
                        (req_tuser == trtt_pkg::MODE_ACK);

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff  <= req_tuser;
         conn_ff  <= IDX_W'(req_tdata[trtt_pkg::CONN_W-1:0]);
         acked_ff <= req_tdata[4];
         empty_ff <= req_tdata[5];
         cwnd_ff  <= req_tdata[21:6];
      end
   end

   // -------------------------------------------------------------------------
   // Table RAM: one port, read data registered
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         tbl_mem[mem_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= tbl_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (mem_wr_en) begin
            vld_ff[mem_addr] <= 1'b1;
         end
         if (mem_rd_en) begin
            rd_vld_ff <= vld_ff[mem_addr];
         end
      end
   end

   // never-written rows read as their reset value
   assign cur_entry = rd_vld_ff ? rd_data_ff : trtt_pkg::ENTRY_RESET;

   // -------------------------------------------------------------------------
   // Timer decisions
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign tw_expire = cur_entry.tw_active &&
                      (cur_entry.tw_rem <= trtt_pkg::TW_W'(si_ff));
   assign rt_expire = (entry_ff.rt_count != '0) &&
                      (entry_ff.rt_rem <= trtt_pkg::RT_REM_W'(si_ff));
   assign half_win  = entry_ff.window >> 1;
   assign cnt_next  = {1'b0, entry_ff.rt_count} + (trtt_pkg::CNT_W+1)'(1);

   // -------------------------------------------------------------------------
   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         trtt_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == trtt_pkg::MODE_SCAN) begin
                  state_in = trtt_pkg::ST_SC_RD;
               end else if (req_mode_ok && req_conn_ok) begin
                  state_in = trtt_pkg::ST_EV_RD;
               end
            end
         end
         trtt_pkg::ST_EV_RD: state_in = trtt_pkg::ST_EV_WR;
         trtt_pkg::ST_EV_WR: state_in = trtt_pkg::ST_IDLE;
         trtt_pkg::ST_SC_RD: state_in = trtt_pkg::ST_SC_TW;
         trtt_pkg::ST_SC_TW: begin
            if (!tw_expire || out_free) begin
               state_in = trtt_pkg::ST_SC_RT;
            end
         end
         trtt_pkg::ST_SC_RT: begin
            if (!rt_expire || out_free) begin
               state_in = (idx_ff == IDX_LAST) ? trtt_pkg::ST_SC_DONE
                                               : trtt_pkg::ST_SC_RD;
            end
         end
         trtt_pkg::ST_SC_DONE: begin
            if (out_free) begin
               state_in = trtt_pkg::ST_IDLE;
            end
         end
         default: state_in = trtt_pkg::ST_IDLE;
      endcase
   end

   // -------------------------------------------------------------------------
   // Outputs: RAM access, row update, result beat
   always_comb begin
      mem_rd_en   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_addr    = idx_ff;
      mem_wr_data = cur_entry;
      entry_in    = entry_ff;
      idx_in      = idx_ff;
      push        = 1'b0;
      res_conn    = trtt_pkg::CONN_W'(idx_ff);
      res_act     = trtt_pkg::ACT_SCAN_DONE;
      res_cwnd    = '0;
      res_ss      = '0;
      res_last    = 1'b0;

      unique case (state_ff)
         trtt_pkg::ST_IDLE: begin
            if (req_accept) begin
               idx_in = '0;
            end
         end

         trtt_pkg::ST_EV_RD: begin
            mem_rd_en = 1'b1;
            mem_addr  = conn_ff;
         end

         // apply the event to the row and write it back
         trtt_pkg::ST_EV_WR: begin
            mem_wr_en = 1'b1;
            mem_addr  = conn_ff;
            unique case (mode_ff)
               trtt_pkg::MODE_TW_START: begin
                  mem_wr_data.tw_active = 1'b1;
                  mem_wr_data.tw_rem    = tw_ff;
               end
               trtt_pkg::MODE_RT_START: begin
                  if (cur_entry.rt_count == '0) begin
                     mem_wr_data.rt_count = trtt_pkg::CNT_W'(1);
                     mem_wr_data.rt_rem   = trtt_pkg::RT_REM_W'(ri_ff);
                  end
                  mem_wr_data.unacked = 1'b1;
               end
               trtt_pkg::MODE_RT_STOP: begin
                  mem_wr_data.rt_count = '0;
               end
               trtt_pkg::MODE_ACK: begin
                  mem_wr_data.window  = cwnd_ff;
                  mem_wr_data.unacked = !empty_ff;
                  if (cur_entry.rt_count != '0) begin
                     if (empty_ff) begin
                        mem_wr_data.rt_count = '0;
                     end else if (acked_ff) begin
                        mem_wr_data.rt_count = trtt_pkg::CNT_W'(1);
                     end
                  end
               end
               default: mem_wr_data = cur_entry;
            endcase
         end

         trtt_pkg::ST_SC_RD: begin
            mem_rd_en = 1'b1;
         end

         // time-wait timer of the row
         trtt_pkg::ST_SC_TW: begin
            entry_in = cur_entry;
            if (tw_expire) begin
               entry_in.tw_active = 1'b0;
               entry_in.tw_rem    = '0;
               push               = out_free;
               res_act            = trtt_pkg::ACT_TW_CLOSE;
               res_cwnd           = cur_entry.window;
            end else if (cur_entry.tw_active) begin
               entry_in.tw_rem = cur_entry.tw_rem - trtt_pkg::TW_W'(si_ff);
            end
         end

         // retransmission timer of the row, then write back
         trtt_pkg::ST_SC_RT: begin
            mem_wr_data = entry_ff;
            if (rt_expire) begin
               mem_wr_data.window = trtt_pkg::WIN_W'(1);
               mem_wr_data.rt_rem = trtt_pkg::RT_REM_W'(ri_ff) << entry_ff.rt_count;
               res_cwnd           = trtt_pkg::WIN_W'(1);
               res_ss             = (half_win == '0) ? trtt_pkg::WIN_W'(1) : half_win;
               push               = out_free;
               if (!entry_ff.unacked) begin
                  mem_wr_data.rt_count = '0;
                  res_act              = trtt_pkg::ACT_DROP;
               end else if (cnt_next > (trtt_pkg::CNT_W+1)'(mr_ff)) begin
                  mem_wr_data.rt_count = '0;
                  res_act              = trtt_pkg::ACT_RESET;
               end else begin
                  mem_wr_data.rt_count = cnt_next[trtt_pkg::CNT_W-1:0];
                  res_act              = trtt_pkg::ACT_RETX;
               end
            end else if (entry_ff.rt_count != '0) begin
               mem_wr_data.rt_rem = entry_ff.rt_rem - trtt_pkg::RT_REM_W'(si_ff);
            end
            if (!rt_expire || out_free) begin
               mem_wr_en = 1'b1;
               idx_in    = idx_ff + IDX_W'(1);
            end
         end

         trtt_pkg::ST_SC_DONE: begin
            push     = out_free;
            res_conn = '0;
            res_act  = trtt_pkg::ACT_SCAN_DONE;
            res_last = 1'b1;
         end

         default: begin
            mem_rd_en = 1'b0;
         end
      endcase
   end

   // -------------------------------------------------------------------------
   // Control and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= trtt_pkg::ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // -------------------------------------------------------------------------
   // Result output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_conn_ff <= res_conn;
         rsp_act_ff  <= res_act;
         rsp_cwnd_ff <= res_cwnd;
         rsp_ss_ff   <= res_ss;
         rsp_last_ff <= res_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_ss_ff, rsp_cwnd_ff, rsp_conn_ff};
   assign rsp_tuser  = rsp_act_ff;
   assign rsp_tlast  = rsp_last_ff;

   // -------------------------------------------------------------------------
   // Assertions
   `ASSERT_CLK(a_push_has_room, push |-> (!rsp_valid_ff || rsp_tready),
      "result beat loaded over one not yet taken")
   `ASSERT_NEVER(a_single_port, mem_rd_en && mem_wr_en,
      "table RAM read and written in the same cycle")
   `ASSERT_CLK(a_read_consumed,
      mem_rd_en |=> (state_ff == trtt_pkg::ST_EV_WR || state_ff == trtt_pkg::ST_SC_TW),
      "table read not followed by its consuming state")
   `ASSERT_CLK(a_done_to_idle,
      (state_ff == trtt_pkg::ST_SC_DONE && push) |=> (state_ff == trtt_pkg::ST_IDLE),
      "scan did not return to idle after its final beat")
   `ASSERT_CLK(a_last_is_done, (push && res_last) |-> (res_act == trtt_pkg::ACT_SCAN_DONE),
      "final scan beat carries a timer action")

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the TCP time-wait / retransmission timer table.
// Events go in on the req stream and expiry actions come back on the rsp
// stream. A predictor in the bench tracks both timers of every connection.
// Each scan tick queues the actions it expects, and every rsp beat is
// checked against the oldest one. A short directed table runs first and
// walks the register extremes. Random phases follow, with varied idling on
// both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CONNS          = 16;
   localparam int SETTLE_CYCLES  = 12;
   localparam int HOLD_CYCLES    = 200;
   localparam int PHASE_REQUESTS = 60;
   localparam int CYCLE_LIMIT    = 500000;

   // one request: fields as carried on the req stream
   typedef struct packed {
      logic [trtt_pkg::MODE_W-1:0] mode;
      logic [trtt_pkg::CONN_W-1:0] conn;
      logic                        acked;
      logic                        empty;
      logic [trtt_pkg::WIN_W-1:0]  cwnd;
   } timer_req_type;

   // one action as carried on the rsp stream
   typedef struct packed {
      logic [trtt_pkg::CONN_W-1:0] conn;
      trtt_pkg::action_type        act;
      logic [trtt_pkg::WIN_W-1:0]  cwnd;
      logic [trtt_pkg::WIN_W-1:0]  ss;
      logic                        last;
   } timer_rsp_type;

   // directed plan: either a register write or a request
   typedef struct {
      bit                 is_csr;
      trtt_pkg::reg_type  csr_idx;
      logic [31:0]        csr_val;
      timer_req_type      rq;
      int                 n_fixed;   // -1: predicted, else number of typed-in actions
      timer_rsp_type      fixed;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // conn[3:0], acked_some[4], buffer_empty[5],
                                  // cwnd_now[21:6], pad[23:22]
   logic [2:0]  req_tuser = '0;   // mode[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // out_conn[3:0], new_cwnd[19:4],
                                  // new_ssthresh[35:20], pad[39:36]
   logic [2:0]  rsp_tuser;        // action[2:0]
   logic        rsp_tlast;
   logic                        csr_psel = 1'b0;
   logic                        csr_penable = 1'b0;
   logic                        csr_pwrite = 1'b0;
   logic [trtt_pkg::CSR_AW-1:0] csr_paddr = '0;
   logic [trtt_pkg::CSR_DW-1:0] csr_pwdata = '0;
   logic [trtt_pkg::CSR_DW-1:0] csr_prdata;
   logic                        csr_pready;

   // predictor copy of the table and registers
   logic                       tw_on    [CONNS];
   logic [31:0]                tw_left  [CONNS];
   logic [2:0]                 rt_tries [CONNS];
   logic [31:0]                rt_left  [CONNS];
   logic                       unacked  [CONNS];
   logic [trtt_pkg::WIN_W-1:0] cwin     [CONNS];
   logic [trtt_pkg::SI_W-1:0]  cfg_scan    = trtt_pkg::SI_RESET;
   logic [trtt_pkg::RI_W-1:0]  cfg_rto     = trtt_pkg::RI_RESET;
   logic [trtt_pkg::TW_W-1:0]  cfg_tw      = trtt_pkg::TW_RESET;
   logic [trtt_pkg::MR_W-1:0]  cfg_retries = trtt_pkg::MR_RESET;

   timer_rsp_type  pending_actions[$];
   plan_row_type   plan[$];
   int          mismatches = 0;
   int unsigned cycle_count = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          hold_asked = 0;
   int          hold_taken = 0;
   int          hold_left = 0;

   tcp_retrans_timewait_timer_table #(.CONNECTIONS(CONNS)) dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < CONNS; i++) begin
         tw_on[i]    = 1'b0;
         tw_left[i]  = '0;
         rt_tries[i] = '0;
         rt_left[i]  = '0;
         unacked[i]  = 1'b0;
         cwin[i]     = trtt_pkg::WIN_W'(1);
      end
   end

   // advance the predicted table by one request, collecting its actions
   function automatic void apply_request(input timer_req_type rq,
                                         ref timer_rsp_type outs[$]);
      logic [trtt_pkg::WIN_W-1:0] half;
      logic [trtt_pkg::WIN_W-1:0] ss;
      int                         tries;
      trtt_pkg::action_type       act;
      for (int i = 0; i < CONNS; i++) begin
         if (rq.mode != trtt_pkg::MODE_SCAN) break;
         if (tw_on[i]) begin
            if (tw_left[i] <= cfg_scan) begin
               tw_on[i]   = 1'b0;
               tw_left[i] = '0;
               outs.push_back('{conn: trtt_pkg::CONN_W'(i), act: trtt_pkg::ACT_TW_CLOSE,
                                cwnd: cwin[i], ss: '0, last: 1'b0});
            end else begin
               tw_left[i] -= cfg_scan;
            end
         end
         if (rt_tries[i] != 0) begin
            if (rt_left[i] <= cfg_scan) begin
               half       = cwin[i] >> 1;
               ss         = (half == 0) ? trtt_pkg::WIN_W'(1) : half;
               cwin[i]    = trtt_pkg::WIN_W'(1);
               rt_left[i] = 32'(cfg_rto) << rt_tries[i];
               tries      = rt_tries[i] + 1;
               if (!unacked[i]) begin
                  tries = 0;
                  act   = trtt_pkg::ACT_DROP;
               end else if (tries > cfg_retries) begin
                  tries = 0;
                  act   = trtt_pkg::ACT_RESET;
               end else begin
                  act = trtt_pkg::ACT_RETX;
               end
               rt_tries[i] = 3'(tries);
               outs.push_back('{conn: trtt_pkg::CONN_W'(i), act: act,
                                cwnd: trtt_pkg::WIN_W'(1), ss: ss, last: 1'b0});
            end else begin
               rt_left[i] -= cfg_scan;
            end
         end
      end
      if (rq.mode == trtt_pkg::MODE_SCAN) begin
         outs.push_back('{conn: '0, act: trtt_pkg::ACT_SCAN_DONE, cwnd: '0, ss: '0,
                          last: 1'b1});
         return;
      end
      if (rq.conn >= CONNS) return;
      case (rq.mode)
         trtt_pkg::MODE_TW_START: begin
            tw_on[rq.conn]   = 1'b1;
            tw_left[rq.conn] = 32'(cfg_tw);
         end
         trtt_pkg::MODE_RT_START: begin
            if (rt_tries[rq.conn] == 0) begin
               rt_tries[rq.conn] = 3'd1;
               rt_left[rq.conn]  = 32'(cfg_rto);
            end
            unacked[rq.conn] = 1'b1;
         end
         trtt_pkg::MODE_RT_STOP: rt_tries[rq.conn] = '0;
         trtt_pkg::MODE_ACK: begin
            cwin[rq.conn]    = rq.cwnd;
            unacked[rq.conn] = !rq.empty;
            if (rt_tries[rq.conn] != 0) begin
               if (rq.acked) rt_tries[rq.conn] = 3'd1;
               if (rq.empty) rt_tries[rq.conn] = '0;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic plan_row_type req_row(input logic [trtt_pkg::MODE_W-1:0] mode,
                                            input logic [trtt_pkg::CONN_W-1:0] conn,
                                            input logic acked, input logic empty,
                                            input logic [trtt_pkg::WIN_W-1:0] cwnd,
                                            input int n_fixed = -1,
                                            input timer_rsp_type fixed = '0);
      plan_row_type row;
      row.is_csr  = 1'b0;
      row.csr_idx = trtt_pkg::REG_SCAN_INTERVAL;
      row.csr_val = '0;
      row.rq      = '{mode: mode, conn: conn, acked: acked, empty: empty, cwnd: cwnd};
      row.n_fixed = n_fixed;
      row.fixed   = fixed;
      return row;
   endfunction

   function automatic plan_row_type csr_row(input trtt_pkg::reg_type idx,
                                            input logic [31:0] value);
      plan_row_type row;
      row         = req_row(trtt_pkg::MODE_SCAN, '0, 1'b0, 1'b0, '0);
      row.is_csr  = 1'b1;
      row.csr_idx = idx;
      row.csr_val = value;
      return row;
   endfunction

   function automatic timer_req_type random_request();
      timer_req_type rq;
      int unsigned   pick;
      pick = $urandom_range(99);
      if (pick < 20)      rq.mode = trtt_pkg::MODE_SCAN;
      else if (pick < 45) rq.mode = trtt_pkg::MODE_RT_START;
      else if (pick < 70) rq.mode = trtt_pkg::MODE_ACK;
      else if (pick < 82) rq.mode = trtt_pkg::MODE_TW_START;
      else if (pick < 94) rq.mode = trtt_pkg::MODE_RT_STOP;
      else                rq.mode = trtt_pkg::MODE_W'($urandom_range(7, 5));
      // half of the traffic on a few connections so retries pile up
      rq.conn  = ($urandom_range(1) == 1) ? trtt_pkg::CONN_W'($urandom_range(3))
                                          : trtt_pkg::CONN_W'($urandom_range(15));
      rq.acked = 1'($urandom_range(1));
      rq.empty = ($urandom_range(3) == 0);
      case ($urandom_range(9))
         0:       rq.cwnd = '0;
         1:       rq.cwnd = '1;
         default: rq.cwnd = trtt_pkg::WIN_W'($urandom);
      endcase
      return rq;
   endfunction

   // offer one beat, wait for acceptance, queue what it should produce
   task automatic send_request(input timer_req_type rq, input int n_fixed = -1,
                               input timer_rsp_type fixed = '0);
      timer_rsp_type outs[$];
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= rq.mode;
      req_tdata  <= {2'b00, rq.cwnd, rq.empty, rq.acked, rq.conn};
      do @(posedge clock); while (!req_tready);
      apply_request(rq, outs);
      if (n_fixed < 0) begin
         foreach (outs[k]) pending_actions.push_back(outs[k]);
      end else if (n_fixed == 1) begin
         pending_actions.push_back(fixed);
      end
      @(negedge clock);
   endtask

   // drop valid, let every queued action arrive and the block go idle
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_actions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // register write followed by a read-back
   task automatic csr_write(input trtt_pkg::reg_type idx, input logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] got;
      case (idx)
         trtt_pkg::REG_SCAN_INTERVAL: begin
            mask     = 32'h000F_FFFF;
            cfg_scan = value[trtt_pkg::SI_W-1:0];
         end
         trtt_pkg::REG_RETRANS_INITIAL: begin
            mask    = 32'h000F_FFFF;
            cfg_rto = value[trtt_pkg::RI_W-1:0];
         end
         trtt_pkg::REG_TIMEWAIT_TIMEOUT: begin
            mask   = 32'h00FF_FFFF;
            cfg_tw = value[trtt_pkg::TW_W-1:0];
         end
         default: begin
            mask        = 32'h0000_0007;
            cfg_retries = value[trtt_pkg::MR_W-1:0];
         end
      endcase
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= trtt_pkg::CSR_AW'({idx, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      if (got !== (value & mask)) begin
         $error("csr reg %0d read-back: expected %0h, got %0h", idx, value & mask, got);
         mismatches++;
      end
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_taken != hold_asked) begin
         hold_taken = hold_asked;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // compare each rsp beat with the oldest queued action
   always @(posedge clock) begin
      timer_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_actions.size() == 0) begin
            $error("rsp beat with nothing expected: conn %0d action %0d",
                   rsp_tdata[3:0], rsp_tuser);
            mismatches++;
         end else begin
            want = pending_actions.pop_front();
            check_field("out_conn", want.conn, rsp_tdata[3:0]);
            check_field("action", want.act, rsp_tuser);
            check_field("new_cwnd", want.cwnd, rsp_tdata[19:4]);
            check_field("new_ssthresh", want.ss, rsp_tdata[35:20]);
            check_field("last", want.last, rsp_tlast);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** tcp_retrans_timewait_timer_table: FAILED **");
         $finish;
      end
   end

   initial begin
      int            idle_by_phase[4];
      int            stall_by_phase[4];
      int            sent;
      int unsigned   si;
      timer_req_type rq;

      idle_by_phase  = '{0, 81, 0, 18};
      stall_by_phase = '{0, 0, 81, 18};

      // directed plan
      plan.push_back(req_row(trtt_pkg::MODE_SCAN, 4'd0, 1'b0, 1'b0, 16'h0000, 1,
                             '{conn: '0, act: trtt_pkg::ACT_SCAN_DONE, cwnd: '0,
                               ss: '0, last: 1'b1}));
      plan.push_back(req_row(trtt_pkg::MODE_W'(5), 4'd3, 1'b1, 1'b1, 16'h1234, 0));
      plan.push_back(req_row(trtt_pkg::MODE_W'(7), 4'd15, 1'b1, 1'b1, 16'hFFFF, 0));
      // an ack on an idle timer must not arm it
      plan.push_back(req_row(trtt_pkg::MODE_ACK, 4'd0, 1'b1, 1'b0, 16'hFFFF));
      plan.push_back(req_row(trtt_pkg::MODE_RT_START, 4'd0, 1'b0, 1'b0, 16'h0000));
      plan.push_back(req_row(trtt_pkg::MODE_RT_START, 4'd0, 1'b0, 1'b0, 16'h0000));
      plan.push_back(req_row(trtt_pkg::MODE_TW_START, 4'd15, 1'b0, 1'b0, 16'h0000));
      plan.push_back(req_row(trtt_pkg::MODE_TW_START, 4'd15, 1'b0, 1'b0, 16'h0000));
      plan.push_back(req_row(trtt_pkg::MODE_RT_START, 4'd15, 1'b0, 1'b0, 16'h0000));
      plan.push_back(csr_row(trtt_pkg::REG_SCAN_INTERVAL, 32'd1048575));
      plan.push_back(csr_row(trtt_pkg::REG_RETRANS_INITIAL, 32'd1));
      plan.push_back(csr_row(trtt_pkg::REG_MAX_RETRIES, 32'd1));
      // everything pending expires, retry limit reached at once
      plan.push_back(req_row(trtt_pkg::MODE_SCAN, 4'd0, 1'b0, 1'b0, 16'h0000));
      plan.push_back(csr_row(trtt_pkg::REG_MAX_RETRIES, 32'd7));
      plan.push_back(req_row(trtt_pkg::MODE_RT_START, 4'd1, 1'b0, 1'b0, 16'h0000));
      plan.push_back(req_row(trtt_pkg::MODE_ACK, 4'd1, 1'b1, 1'b1, 16'h0005));
      plan.push_back(req_row(trtt_pkg::MODE_RT_START, 4'd1, 1'b0, 1'b0, 16'h0000));
      plan.push_back(req_row(trtt_pkg::MODE_ACK, 4'd2, 1'b0, 1'b1, 16'h0000));
      plan.push_back(req_row(trtt_pkg::MODE_RT_START, 4'd2, 1'b0, 1'b0, 16'h0000));
      plan.push_back(req_row(trtt_pkg::MODE_RT_STOP, 4'd3, 1'b0, 1'b0, 16'h0000));
      plan.push_back(req_row(trtt_pkg::MODE_RT_START, 4'd3, 1'b0, 1'b0, 16'h0000));
      plan.push_back(req_row(trtt_pkg::MODE_RT_STOP, 4'd3, 1'b0, 1'b0, 16'h0000));
      plan.push_back(req_row(trtt_pkg::MODE_SCAN, 4'd0, 1'b0, 1'b0, 16'h0000));
      plan.push_back(csr_row(trtt_pkg::REG_SCAN_INTERVAL, 32'd1));
      plan.push_back(csr_row(trtt_pkg::REG_RETRANS_INITIAL, 32'd1048575));
      plan.push_back(csr_row(trtt_pkg::REG_TIMEWAIT_TIMEOUT, 32'd1));
      plan.push_back(req_row(trtt_pkg::MODE_TW_START, 4'd4, 1'b0, 1'b0, 16'h0000));
      plan.push_back(req_row(trtt_pkg::MODE_ACK, 4'd1, 1'b1, 1'b0, 16'h8000));
      plan.push_back(req_row(trtt_pkg::MODE_SCAN, 4'd0, 1'b0, 1'b0, 16'h0000));
      plan.push_back(req_row(trtt_pkg::MODE_SCAN, 4'd0, 1'b0, 1'b0, 16'h0000));
      plan.push_back(csr_row(trtt_pkg::REG_TIMEWAIT_TIMEOUT, 32'd16777215));
      plan.push_back(req_row(trtt_pkg::MODE_TW_START, 4'd7, 1'b0, 1'b0, 16'h0000));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[r]) begin
         if (plan[r].is_csr) begin
            settle();
            csr_write(plan[r].csr_idx, plan[r].csr_val);
         end else begin
            send_request(plan[r].rq, plan[r].n_fixed, plan[r].fixed);
         end
      end

      // random phases, each with fresh registers and its own idling mix
      for (int ph = 0; ph < 4; ph++) begin
         settle();
         si = $urandom_range(5000, 500);
         csr_write(trtt_pkg::REG_SCAN_INTERVAL, si);
         csr_write(trtt_pkg::REG_RETRANS_INITIAL, si * $urandom_range(3, 1));
         csr_write(trtt_pkg::REG_TIMEWAIT_TIMEOUT, si * $urandom_range(6, 1));
         csr_write(trtt_pkg::REG_MAX_RETRIES, $urandom_range(7, 1));
         idle_pct  = idle_by_phase[ph];
         stall_pct = stall_by_phase[ph];
         // long receiver hold-off while beats keep coming
         if (ph == 0) hold_asked++;
         sent = 0;
         while (sent < PHASE_REQUESTS) begin
            rq = random_request();
            send_request(rq);
            if (rq.mode <= trtt_pkg::MODE_ACK) sent++;
         end
      end

      settle();
      if (mismatches == 0) begin
         $display("** tcp_retrans_timewait_timer_table: PASSED **");
      end else begin
         $display("** tcp_retrans_timewait_timer_table: FAILED **");
      end
      $finish;
   end

endmodule
